>>> src/sssb_pkg.sv
// Shared types and constants for the seven-segment scan driver with blink.
// No dependencies; used by seven_segment_scan_with_blink_core.
`default_nettype none

package sssb_pkg;

    localparam int unsigned ScanW  = 24;
    localparam int unsigned BlinkW = 32;
    localparam int unsigned SegW   = 8;
    localparam int unsigned DigitN = 4;
    localparam int unsigned DigitW = 2;

    localparam logic [ScanW-1:0]  ScanPeriodRst  = 24'd96000;
    localparam logic [BlinkW-1:0] BlinkPeriodRst = 32'd24000000;
    localparam logic [ScanW-1:0]  ScanMax        = {ScanW{1'b1}};
    localparam logic [BlinkW-1:0] BlinkMax       = {BlinkW{1'b1}};

    localparam logic [SegW-1:0] PointBit    = 8'h80;
    localparam logic [SegW-1:0] SegmentMask = 8'h7F;

    // configuration register indexes
    typedef enum logic {
        t_REG_SCAN_PERIOD  = 1'b0,
        t_REG_BLINK_PERIOD = 1'b1
    } t_reg_index;

    // blink modes (0..3 select a digit)
    localparam logic [2:0] ModeBlinkPoint = 3'd4;
    localparam logic [2:0] ModeBlinkAll   = 3'd5;
    localparam logic [2:0] ModeOffFirst   = 3'd6;

    typedef logic [SegW-1:0] t_segments;

    // code page: digits 0-9, letters A, Y, N, H, P, then a dash
    function automatic t_segments glyph(input logic [3:0] code);
        t_segments seg;
        case (code)
            4'h0: seg = 8'h3F;
            4'h1: seg = 8'h06;
            4'h2: seg = 8'h5B;
            4'h3: seg = 8'h4F;
            4'h4: seg = 8'h66;
            4'h5: seg = 8'h6D;
            4'h6: seg = 8'h7D;
            4'h7: seg = 8'h07;
            4'h8: seg = 8'h7F;
            4'h9: seg = 8'h6F;
            4'hA: seg = 8'h77;
            4'hB: seg = 8'h6E;
            4'hC: seg = 8'h37;
            4'hD: seg = 8'h76;
            4'hE: seg = 8'h73;
            default: seg = 8'h40;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

>>> src/seven_segment_scan_with_blink_core.sv
// Four-digit multiplexed seven-segment scan driver with blinking.
// Uses sssb_pkg for the code page, reset values and register indexes.
// A tick that completes a scan period shows its result in the next cycle.
// Throughput: one tick per cycle; the only stall is a full, unread result register.
// Reset (i_rst_n low, synchronous): periods return to 96000 / 24000000 ticks,
// counters, digit index and blink phase clear, no result is pending.
`default_nettype none

module seven_segment_scan_with_blink_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tick stream; tdata: display_word[31:0], point_position[34:32],
    // blink_mode[37:35], zero fill [39:38]
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,
    // result stream; tdata: segment_lines[7:0], digit_enable[11:8],
    // digit_number[13:12], zero fill [15:14]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,
    // configuration writes: index 0 scan_period, index 1 blink_period
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int unsigned ScanW  = sssb_pkg::ScanW;
    localparam int unsigned BlinkW = sssb_pkg::BlinkW;

    // configuration registers
    logic [ScanW-1:0]  r_scan_period;
    logic [BlinkW-1:0] r_blink_period;

    // tick state
    logic [ScanW-1:0]  r_scan_ticks,  n_scan_ticks;
    logic [BlinkW-1:0] r_blink_ticks, n_blink_ticks;
    logic [1:0]        r_digit,       n_digit;
    logic              r_blink_phase, n_blink_phase;

    // result register
    logic              r_out_valid;
    logic [15:0]       r_out_data;

    // unpacked input fields
    logic [31:0] display_word;
    logic [2:0]  point_position;
    logic [2:0]  blink_mode;

    logic              in_accept;
    logic              scan_step;
    logic              blink_on;
    logic              toggle;
    logic [ScanW-1:0]  scan_inc;
    logic [BlinkW-1:0] blink_inc;
    logic [7:0]        code_byte;
    sssb_pkg::t_segments seg_lit;
    sssb_pkg::t_segments seg_out;
    logic [3:0]        enable_out;

    assign display_word   = i_s_axis_tdata[31:0];
    assign point_position = i_s_axis_tdata[34:32];
    assign blink_mode     = i_s_axis_tdata[37:35];

    // Take a new tick whenever the result register is empty or draining now.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Count this tick first, saturating at the counter maximum.
    assign scan_inc  = (r_scan_ticks  == sssb_pkg::ScanMax)  ? r_scan_ticks
                                                             : r_scan_ticks + 1'b1;
    assign blink_inc = (r_blink_ticks == sssb_pkg::BlinkMax) ? r_blink_ticks
                                                             : r_blink_ticks + 1'b1;
    assign scan_step = (scan_inc >= r_scan_period);
    assign blink_on  = (blink_mode < sssb_pkg::ModeOffFirst);
    assign toggle    = blink_on && (blink_inc >= r_blink_period);

    // Advance to the next digit and decode its low nibble, add the point.
    always_comb begin
        n_digit   = r_digit + 2'd1;
        code_byte = display_word[8*n_digit +: 8];
        seg_lit   = sssb_pkg::glyph(code_byte[3:0]);
        if (point_position == {1'b0, n_digit}) begin
            seg_lit = seg_lit | sssb_pkg::PointBit;
        end
        enable_out = 4'b0001 << n_digit;
    end

    // Blank with the phase held before this step.
    always_comb begin
        seg_out = seg_lit;
        if (blink_on && r_blink_phase) begin
            case (blink_mode)
                sssb_pkg::ModeBlinkAll:   seg_out = '0;
                sssb_pkg::ModeBlinkPoint: seg_out = seg_lit & sssb_pkg::SegmentMask;
                default: begin
                    if (blink_mode == {1'b0, n_digit}) begin
                        seg_out = seg_lit & sssb_pkg::PointBit;
                    end
                end
            endcase
        end
    end

    // Next state for an accepted tick; the phase flips only at a scan step.
    always_comb begin
        n_scan_ticks  = scan_step ? '0 : scan_inc;
        n_blink_ticks = blink_inc;
        n_blink_phase = r_blink_phase;
        if (scan_step && toggle) begin
            n_blink_ticks = '0;
            n_blink_phase = !r_blink_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_period  <= sssb_pkg::ScanPeriodRst;
            r_blink_period <= sssb_pkg::BlinkPeriodRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sssb_pkg::t_REG_SCAN_PERIOD:  r_scan_period  <= i_cfg_data[ScanW-1:0];
                sssb_pkg::t_REG_BLINK_PERIOD: r_blink_period <= i_cfg_data[BlinkW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_ticks  <= '0;
            r_blink_ticks <= '0;
            r_digit       <= '0;
            r_blink_phase <= 1'b0;
        end else if (in_accept) begin
            r_scan_ticks  <= n_scan_ticks;
            r_blink_ticks <= n_blink_ticks;
            r_blink_phase <= n_blink_phase;
            if (scan_step) begin
                r_digit <= n_digit;
            end
        end
    end

    // Load a result on a scan step; drop it once the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && scan_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && scan_step) begin
            r_out_data <= {2'b00, n_digit, enable_out, seg_out};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // The enable always matches the digit number of a pending result.
    a_enable_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[11:8] == (4'b0001 << o_m_axis_tdata[13:12])))
        else $error("digit enable does not match digit number");

    // A phase flip clears the blink counter and needs an accepted tick at a scan step.
    a_phase_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_blink_phase != $past(r_blink_phase))
            |-> ((r_blink_ticks == '0) && $past(in_accept) && $past(scan_step)))
        else $error("blink phase changed outside a scan step");

    // A scan step advances the digit by one and shows that digit.
    a_digit_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && scan_step) |=> (r_digit == $past(r_digit) + 2'd1)
            && o_m_axis_tvalid && (o_m_axis_tdata[13:12] == r_digit))
        else $error("digit index did not advance on a scan step");

endmodule

`default_nettype wire
